// ===== sv/console_line_editor_defines.svh =====
// assertion helpers shared by the line editor modules
// they expect clk and arst_n in the enclosing module
`ifndef CONSOLE_LINE_EDITOR_DEFINES_SVH
`define CONSOLE_LINE_EDITOR_DEFINES_SVH

// same-cycle implication
`define CLE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CLE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/cle_pkg.sv =====
`default_nettype none

package cle_pkg;

	localparam int CLE_BUFFER_DEPTH = 64;
	localparam int QUEUE_DEPTH = 4;
	localparam int LEN_W = 6;
	localparam int STORE_W = 7;
	localparam int SUM_W = 9;

	// result kinds
	localparam logic [1:0] KIND_ECHO = 2'd0;
	localparam logic [1:0] KIND_BELL = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;
	localparam logic [1:0] KIND_LINE = 2'd3;

	// commands from the front to the back
	localparam logic [1:0] CMD_PUT = 2'd0;
	localparam logic [1:0] CMD_BELL = 2'd1;
	localparam logic [1:0] CMD_ERASE = 2'd2;
	localparam logic [1:0] CMD_LINE = 2'd3;

	localparam logic [7:0] CH_BELL = 8'd7;
	localparam logic [7:0] CH_BS = 8'd8;
	localparam logic [7:0] CH_NL = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;

	// register indexes
	localparam logic [1:0] CFG_LINE_LIMIT = 2'd0;
	localparam logic [1:0] CFG_SCREEN_WIDTH = 2'd1;
	localparam logic [1:0] CFG_PROMPT_WIDTH = 2'd2;

	localparam logic [5:0] RST_LINE_LIMIT = 6'd63;
	localparam logic [7:0] RST_SCREEN_WIDTH = 8'd80;
	localparam logic [7:0] RST_PROMPT_WIDTH = 8'd2;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] ch;
		logic [LEN_W-1:0] len;
	} cmd_t;

endpackage

`default_nettype wire

// ===== sv/console_line_editor.sv =====
// console line editor
// input channel: in_valid/in_ready with char_in, one received byte per transfer
// output channel: out_valid/out_ready with kind, out_char, line_length, last;
//   last marks the final result of one input byte, a dropped byte gives none
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
//   write only while no byte is in flight
// a front stage classifies each byte, keeps the character count and writes the
// line store; a four-entry command queue feeds a back stage that expands each
// command into results through a single output register
// ordinary bytes: the front takes a new byte while earlier commands still wait in the queue
// backspace with a nonzero count and screen width runs a 9-step remainder unit in the front;
//   no byte is taken until it has pushed its bell or erase command
// newline: one header result, then each stored character is read from the registered
//   line store and loaded into the output register; no input is taken until the last
//   result of the line is loaded into the output register
// reset: count cleared, registers back to 63/80/2, line store keeps its contents
// a stalled receiver holds the output register; the queue fills and then in_ready drops
`default_nettype none

module console_line_editor
	import cle_pkg::*;
#(
	parameter int BUFFER_DEPTH = CLE_BUFFER_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] char_in,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [7:0] cfg_data,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] kind,
	output logic [7:0] out_char,
	output logic [LEN_W-1:0] line_length,
	output logic last
);

	localparam int AW = $clog2(BUFFER_DEPTH);

	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic q_empty;
	logic pop;
	cmd_t q_head;
	logic line_done;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [STORE_W-1:0] ram_wdata;
	logic ram_re;
	logic [AW-1:0] ram_raddr;
	logic [STORE_W-1:0] ram_rdata;

	cle_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_in(char_in),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.push_cmd(push_cmd),
		.q_full(q_full),
		.line_done(line_done),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata)
	);

	cle_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.full(q_full),
		.pop(pop),
		.head(q_head),
		.empty(q_empty)
	);

	cle_ram #(.WIDTH(STORE_W), .DEPTH(BUFFER_DEPTH)) u_store (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	cle_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_head(q_head),
		.pop(pop),
		.ram_re(ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.line_done(line_done),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.out_char(out_char),
		.line_length(line_length),
		.last(last)
	);

endmodule

`default_nettype wire

// ===== sv/cle_ram.sv =====
`default_nettype none

module cle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/cle_queue.sv =====
`default_nettype none

`include "console_line_editor_defines.svh"

module cle_queue
	import cle_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire cmd_t push_cmd,
	output logic full,
	input wire logic pop,
	output cmd_t head,
	output logic empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	assign full = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (fill_q == '0);
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

	`CLE_ASSERT_NOW(a_no_push_full, push, !full, "command pushed into a full queue")
	`CLE_ASSERT_NOW(a_no_pop_empty, pop, !empty, "command popped from an empty queue")

endmodule

`default_nettype wire

// ===== sv/cle_front.sv =====
`default_nettype none

`include "console_line_editor_defines.svh"

module cle_front
	import cle_pkg::*;
#(
	parameter int BUFFER_DEPTH = CLE_BUFFER_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] char_in,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [7:0] cfg_data,
	output logic push,
	output cmd_t push_cmd,
	input wire logic q_full,
	input wire logic line_done,
	output logic ram_we,
	output logic [$clog2(BUFFER_DEPTH)-1:0] ram_waddr,
	output logic [STORE_W-1:0] ram_wdata
);

	localparam int CW = $clog2(BUFFER_DEPTH);
	localparam logic [LEN_W-1:0] LIMIT_MAX = LEN_W'(BUFFER_DEPTH - 1);

	localparam logic FR_IDLE = 1'b0;
	localparam logic FR_MOD = 1'b1;

	logic st_q;
	logic [CW-1:0] count_q;
	logic pend_q;
	logic [5:0] limit_q;
	logic [7:0] sw_q;
	logic [7:0] prompt_q;
	logic [SUM_W-1:0] sum_q;
	logic [7:0] rem_q;
	logic [3:0] bit_q;

	logic acc;
	logic [LEN_W-1:0] lim;
	logic at_limit;
	logic [8:0] trial;
	logic [7:0] rem_nx;
	logic [CW-1:0] count_nx;
	logic set_pend;
	logic go_mod;
	logic mod_end;

	assign in_ready = (st_q == FR_IDLE) && !q_full && !pend_q;
	assign cfg_ready = 1'b1;
	assign acc = in_valid && in_ready;

	assign lim = (limit_q > LIMIT_MAX) ? LIMIT_MAX : limit_q;
	assign at_limit = (LEN_W'(count_q) >= lim);

	// one restoring step of (count + prompt) mod screen width
	assign trial = {rem_q, sum_q[bit_q]};
	assign rem_nx = (trial >= {1'b0, sw_q}) ? 8'(trial - {1'b0, sw_q}) : trial[7:0];
	assign mod_end = (st_q == FR_MOD) && (bit_q == '0);

	assign ram_waddr = count_q;
	assign ram_wdata = char_in[STORE_W-1:0];

	always_comb begin
		push = 1'b0;
		push_cmd = '0;
		ram_we = 1'b0;
		count_nx = count_q;
		set_pend = 1'b0;
		go_mod = 1'b0;
		if (acc) begin
			if (char_in == CH_NL) begin
				push = 1'b1;
				push_cmd.op = CMD_LINE;
				push_cmd.len = LEN_W'(count_q);
				count_nx = '0;
				set_pend = 1'b1;
			end else if (char_in == CH_BS) begin
				if (count_q == '0) begin
					push = 1'b1;
					push_cmd.op = CMD_BELL;
				end else if (sw_q == '0) begin
					push = 1'b1;
					push_cmd.op = CMD_ERASE;
					count_nx = count_q - CW'(1);
				end else begin
					go_mod = 1'b1;
				end
			end else if (at_limit) begin
				push = 1'b1;
				push_cmd.op = CMD_BELL;
			end else if (!char_in[7]) begin
				push = 1'b1;
				push_cmd.op = CMD_PUT;
				push_cmd.ch = char_in;
				ram_we = 1'b1;
				count_nx = count_q + CW'(1);
			end
		end
		if (mod_end) begin
			push = 1'b1;
			if (rem_nx == '0) begin
				push_cmd.op = CMD_BELL;
			end else begin
				push_cmd.op = CMD_ERASE;
				count_nx = count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_mod) begin
			sum_q <= SUM_W'(count_q) + SUM_W'(prompt_q);
			rem_q <= '0;
		end else if (st_q == FR_MOD) begin
			rem_q <= rem_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= FR_IDLE;
			count_q <= '0;
			pend_q <= 1'b0;
			bit_q <= '0;
			limit_q <= RST_LINE_LIMIT;
			sw_q <= RST_SCREEN_WIDTH;
			prompt_q <= RST_PROMPT_WIDTH;
		end else begin
			count_q <= count_nx;
			if (set_pend) begin
				pend_q <= 1'b1;
			end else if (line_done) begin
				pend_q <= 1'b0;
			end
			if (go_mod) begin
				st_q <= FR_MOD;
				bit_q <= 4'(SUM_W - 1);
			end else if (mod_end) begin
				st_q <= FR_IDLE;
			end else if (st_q == FR_MOD) begin
				bit_q <= bit_q - 4'd1;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LINE_LIMIT: limit_q <= cfg_data[5:0];
					CFG_SCREEN_WIDTH: sw_q <= cfg_data;
					CFG_PROMPT_WIDTH: prompt_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	`CLE_ASSERT_NOW(a_mod_needs_room, st_q == FR_MOD, (|sw_q) && (|count_q), "bad wrap check")

endmodule

`default_nettype wire

// ===== sv/cle_back.sv =====
`default_nettype none

`include "console_line_editor_defines.svh"

module cle_back
	import cle_pkg::*;
#(
	parameter int BUFFER_DEPTH = CLE_BUFFER_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_empty,
	input wire cmd_t q_head,
	output logic pop,
	output logic ram_re,
	output logic [$clog2(BUFFER_DEPTH)-1:0] ram_raddr,
	input wire logic [STORE_W-1:0] ram_rdata,
	output logic line_done,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] kind,
	output logic [7:0] out_char,
	output logic [LEN_W-1:0] line_length,
	output logic last
);

	localparam int CW = $clog2(BUFFER_DEPTH);

	localparam logic [1:0] BK_IDLE = 2'd0;
	localparam logic [1:0] BK_RUN = 2'd1;
	localparam logic [1:0] BK_RD = 2'd2;
	localparam logic [1:0] BK_CH = 2'd3;

	logic [1:0] st_q;
	cmd_t cmd_q;
	logic [1:0] step_q;
	logic [CW-1:0] pos_q;
	logic out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] char_q;
	logic [LEN_W-1:0] len_q;
	logic last_q;

	logic slot_free;
	logic last_ch;
	logic load_out;

	assign slot_free = !out_valid_q || out_ready;
	assign load_out = slot_free && ((st_q == BK_RUN) || (st_q == BK_CH));
	assign pop = (st_q == BK_IDLE) && !q_empty;
	assign ram_re = (st_q == BK_RD);
	assign ram_raddr = pos_q;
	assign last_ch = ((LEN_W'(pos_q) + LEN_W'(1)) == cmd_q.len);
	assign line_done = slot_free && (((st_q == BK_RUN) && (cmd_q.op == CMD_LINE)
		&& (cmd_q.len == '0)) || ((st_q == BK_CH) && last_ch));

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign out_char = char_q;
	assign line_length = len_q;
	assign last = last_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_head;
		end
		if ((st_q == BK_RUN) && slot_free) begin
			len_q <= '0;
			case (cmd_q.op)
				CMD_PUT: begin
					kind_q <= KIND_ECHO;
					char_q <= cmd_q.ch;
					last_q <= 1'b1;
				end
				CMD_BELL: begin
					kind_q <= KIND_BELL;
					char_q <= CH_BELL;
					last_q <= 1'b1;
				end
				CMD_ERASE: begin
					kind_q <= KIND_ECHO;
					char_q <= (step_q == 2'd1) ? CH_SPACE : CH_BS;
					last_q <= (step_q == 2'd2);
				end
				default: begin
					kind_q <= KIND_DONE;
					char_q <= CH_NL;
					len_q <= cmd_q.len;
					last_q <= (cmd_q.len == '0);
				end
			endcase
		end else if ((st_q == BK_CH) && slot_free) begin
			kind_q <= KIND_LINE;
			char_q <= {1'b0, ram_rdata};
			len_q <= '0;
			last_q <= last_ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			step_q <= '0;
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				BK_IDLE: begin
					if (pop) begin
						step_q <= '0;
						pos_q <= '0;
						st_q <= BK_RUN;
					end
				end
				BK_RUN: begin
					if (slot_free) begin
						case (cmd_q.op)
							CMD_ERASE: begin
								if (step_q == 2'd2) begin
									st_q <= BK_IDLE;
								end else begin
									step_q <= step_q + 2'd1;
								end
							end
							CMD_LINE: st_q <= (cmd_q.len == '0) ? BK_IDLE : BK_RD;
							default: st_q <= BK_IDLE;
						endcase
					end
				end
				BK_RD: st_q <= BK_CH;
				BK_CH: begin
					if (slot_free) begin
						if (last_ch) begin
							st_q <= BK_IDLE;
						end else begin
							pos_q <= pos_q + CW'(1);
							st_q <= BK_RD;
						end
					end
				end
				default: st_q <= BK_IDLE;
			endcase
		end
	end

	`CLE_ASSERT_NOW(a_done_on_line, line_done, cmd_q.op == CMD_LINE, "line end without line")
	`CLE_ASSERT_NXT(a_done_idle, line_done, (st_q == BK_IDLE) && out_valid_q && last_q, "open line")

endmodule

`default_nettype wire
